// File: rtl/fcd_pkg.sv
// Shared types and constants for the frame channel demultiplexer.
package fcd_pkg;

  localparam int COMMAND_DEPTH_DEF = 32;

  localparam logic [2:0] CH_RADIO1   = 3'd0;
  localparam logic [2:0] CH_RADIO2   = 3'd1;
  localparam logic [2:0] CH_FLAGS    = 3'd2;
  localparam logic [2:0] CH_KEYER    = 3'd3;
  localparam logic [2:0] CH_KEYBOARD = 3'd4;
  localparam logic [2:0] CH_CONTROL  = 3'd5;

  localparam logic [2:0] COUNT_SAT   = 3'd4;
  localparam logic [2:0] POS_BYTE1   = 3'd1;
  localparam logic [2:0] POS_BYTE2   = 3'd2;
  localparam logic [2:0] POS_BYTE3   = 3'd3;
  localparam logic [2:0] FRAME_FLAGS = 3'd0;
  localparam logic [2:0] FRAME_CTRL  = 3'd1;
  localparam logic [2:0] FRAME_KEYER = 3'd2;
  localparam logic [2:0] FRAME_LAST  = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } fcd_state_t;

  typedef struct packed {
    logic proc;
    logic rd_issue;
    logic drain_load;
  } fcd_cmd_t;

  typedef struct packed {
    logic in_full;
    logic slot_free;
    logic start_drain;
    logic rd_last;
  } fcd_stat_t;

endpackage

// File: rtl/fcd_controller.sv
// Sequencer that schedules item processing and command store drains.
module fcd_controller
  import fcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  fcd_stat_t stat,
  output fcd_cmd_t  cmd
);

  fcd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_full && stat.slot_free) begin
          cmd.proc = 1'b1;
          if (stat.start_drain) begin
            state_next = ST_DRAIN_RD;
          end
        end
      end
      ST_DRAIN_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_DRAIN_OUT;
      end
      ST_DRAIN_OUT: begin
        if (stat.slot_free) begin
          cmd.drain_load = 1'b1;
          state_next     = stat.rd_last ? ST_IDLE : ST_DRAIN_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/fcd_datapath.sv
// Frame decoding state, command store memory and output register.
module fcd_datapath
  import fcd_pkg::*;
#(
  parameter int COMMAND_DEPTH = COMMAND_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] channel,
  output logic [7:0] data_byte,
  output logic       last,
  input  fcd_cmd_t   cmd,
  output fcd_stat_t  stat
);

  localparam int LEN_W  = $clog2(COMMAND_DEPTH + 1);
  localparam int ADDR_W = $clog2(COMMAND_DEPTH);

  logic             in_full;
  logic [7:0]       in_byte;
  logic [7:0]       sync_word;
  logic             sync_valid;
  logic [2:0]       frame_count;
  logic [2:0]       byte_position;
  logic [7:0]       command_head;
  logic             command_active;
  logic [LEN_W-1:0] command_length;
  logic [7:0]       command_store [COMMAND_DEPTH];
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]       rd_data;

  logic             is_sync;
  logic [2:0]       pos_next;
  logic             data_ok;
  logic [7:0]       value;
  logic             emit;
  logic [2:0]       emit_ch;
  logic             ctrl_byte;
  logic             opening;
  logic             match;
  logic             active_eff;
  logic [LEN_W-1:0] len_eff;
  logic             store_ok;

  assign in_ready = !in_full;

  // Decode of the held item against the current frame state.
  always_comb begin
    is_sync   = !in_byte[7];
    pos_next  = (byte_position < COUNT_SAT) ? byte_position + 3'd1 : byte_position;
    data_ok   = !is_sync && sync_valid && (frame_count <= FRAME_LAST);
    value     = {sync_word[0], in_byte[6:0]};
    emit      = 1'b0;
    emit_ch   = CH_RADIO1;
    ctrl_byte = 1'b0;
    if (data_ok) begin
      unique case (pos_next)
        POS_BYTE1: begin
          emit    = sync_word[5];
          emit_ch = CH_RADIO1;
          value   = {sync_word[2], in_byte[6:0]};
        end
        POS_BYTE2: begin
          emit    = sync_word[4];
          emit_ch = CH_RADIO2;
          value   = {sync_word[1], in_byte[6:0]};
        end
        POS_BYTE3: begin
          if (frame_count == FRAME_CTRL) begin
            ctrl_byte = 1'b1;
          end else begin
            emit    = sync_word[3];
            emit_ch = (frame_count == FRAME_FLAGS) ? CH_FLAGS :
                      (frame_count == FRAME_KEYER) ? CH_KEYER : CH_KEYBOARD;
          end
        end
        default: emit = 1'b0;
      endcase
    end
    opening    = ctrl_byte && !sync_word[3] && !value[7];
    match      = ctrl_byte && !sync_word[3] && value[7] && command_active &&
                 (value == {1'b1, command_head[6:0]});
    active_eff = opening || command_active;
    len_eff    = opening ? '0 : command_length;
    store_ok   = ctrl_byte && active_eff && (len_eff < LEN_W'(COMMAND_DEPTH));
  end

  assign stat.in_full     = in_full;
  assign stat.slot_free   = !out_valid || out_ready;
  assign stat.start_drain = store_ok && match;
  assign stat.rd_last     = (LEN_W'(rd_idx) + LEN_W'(1)) == command_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      sync_word      <= '0;
      sync_valid     <= 1'b1;
      frame_count    <= '0;
      byte_position  <= '0;
      command_head   <= '0;
      command_active <= 1'b1;
      command_length <= '0;
      out_valid      <= 1'b0;
      rd_idx         <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (cmd.proc) begin
        in_full <= 1'b0;
      end
      if ((cmd.proc && emit) || cmd.drain_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.proc) begin
        if (is_sync) begin
          if (!in_byte[6]) begin
            frame_count <= '0;
          end else if (frame_count < COUNT_SAT) begin
            frame_count <= frame_count + 3'd1;
          end
          byte_position <= '0;
          sync_word     <= in_byte;
          sync_valid    <= 1'b1;
        end else begin
          byte_position <= pos_next;
          if (sync_valid && frame_count > FRAME_LAST) begin
            sync_valid <= 1'b0;
          end
        end
        // An opening byte is always stored as the first entry, which sets the length.
        if (opening) begin
          command_head   <= value;
          command_active <= 1'b1;
        end
        if (store_ok) begin
          command_length <= len_eff + LEN_W'(1);
          if (match) begin
            command_active <= 1'b0;
          end
        end
        rd_idx <= '0;
      end
      if (cmd.drain_load) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
    if (cmd.proc && emit) begin
      channel   <= emit_ch;
      data_byte <= value;
      last      <= 1'b1;
    end else if (cmd.drain_load) begin
      channel   <= CH_CONTROL;
      data_byte <= rd_data;
      last      <= stat.rd_last;
    end
  end

  // Command store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.proc && store_ok) begin
      command_store[len_eff[ADDR_W-1:0]] <= value;
    end
    if (cmd.rd_issue) begin
      rd_data <= command_store[rd_idx];
    end
  end

  a_proc_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd.proc |-> in_full)
    else $error("item processed with empty input register");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_load |-> (!out_valid || out_ready))
    else $error("drain overwrote a pending result");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    command_length <= LEN_W'(COMMAND_DEPTH))
    else $error("command length beyond store depth");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (LEN_W'(rd_idx) < command_length))
    else $error("drain read beyond stored command bytes");

endmodule

// File: rtl/frame_channel_demultiplexer.sv
// Top level of the frame channel demultiplexer.
// A received item is one serial byte. Sync bytes (bit 7 clear) open a frame and carry the
// valid marks and top bits of the three data bytes that follow; data bytes are rebuilt to
// eight bits and sent as single-item runs to radio 1, radio 2, flags, keyer or keyboard,
// each with last set. In frame 1 the third byte is a control byte that is gathered into a
// command store of COMMAND_DEPTH entries; when the closing byte matches the opening one the
// whole store is sent as one run on the control channel, last marking its final item.
// Timing: an input register takes an item whenever it is empty. A held item is decoded and
// retired once the output register is free and no command run is draining, and the input
// register is ready again in the cycle after. A result waiting at the output keeps the held
// item from retiring, so the link side is then held up as well. A command run drains from
// the store memory one item at a time, by a registered read and then the load into the
// output register; meanwhile at most one further input item is taken and waits. There is
// no clearing pass after reset.
module frame_channel_demultiplexer
  import fcd_pkg::*;
#(
  parameter int COMMAND_DEPTH = COMMAND_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [2:0] channel,
  output logic [7:0] data_byte,
  output logic       last,
  output logic       out_valid,
  input  logic       out_ready
);

  fcd_cmd_t  cmd;
  fcd_stat_t stat;

  // The controller decides when the held item is retired and paces the store drain.
  fcd_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // The datapath holds the frame state, the command store and the output register.
  fcd_datapath #(
    .COMMAND_DEPTH (COMMAND_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .data_byte (data_byte),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: bench/fcd_route_monitor.sv
// Monitor that predicts the demultiplexer's routed bytes and compares them with the outputs.
module fcd_route_monitor
  import fcd_pkg::*;
#(
  parameter int COMMAND_DEPTH = COMMAND_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] channel,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       out_valid,
  input  logic       out_ready,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [2:0] ch;
    logic [7:0] value;
    logic       tail;
  } routed_byte_t;

  routed_byte_t expected_routes[$];

  // Own copy of the link and command state.
  logic [7:0] link_sync;
  logic       link_sync_ok;
  logic [2:0] link_frame;
  logic [2:0] byte_no;
  logic [7:0] cmd_head;
  logic       cmd_gathering;
  int         cmd_len;
  logic [7:0] cmd_store [COMMAND_DEPTH];

  task automatic queue_route(input logic [2:0] ch, input logic [7:0] value, input logic tail);
    routed_byte_t r;
    r.ch    = ch;
    r.value = value;
    r.tail  = tail;
    expected_routes.push_back(r);
  endtask

  task automatic route_link_byte(input logic [7:0] rx);
    logic [7:0] rebuilt;
    logic       closes;
    if (!rx[7]) begin
      if (!rx[6]) begin
        link_frame = FRAME_FLAGS;
      end else if (link_frame < COUNT_SAT) begin
        link_frame = link_frame + 3'd1;
      end
      byte_no      = 3'd0;
      link_sync    = rx;
      link_sync_ok = 1'b1;
      return;
    end
    if (byte_no < COUNT_SAT) byte_no = byte_no + 3'd1;
    if (!link_sync_ok) return;
    // A data byte in a frame beyond the fourth spoils the sequence until the next sync byte.
    if (link_frame > FRAME_LAST) begin
      link_sync_ok = 1'b0;
      return;
    end
    case (byte_no)
      POS_BYTE1: begin
        if (link_sync[5]) queue_route(CH_RADIO1, {link_sync[2], rx[6:0]}, 1'b1);
      end
      POS_BYTE2: begin
        if (link_sync[4]) queue_route(CH_RADIO2, {link_sync[1], rx[6:0]}, 1'b1);
      end
      POS_BYTE3: begin
        rebuilt = {link_sync[0], rx[6:0]};
        if (link_frame != FRAME_CTRL) begin
          if (link_sync[3]) begin
            case (link_frame)
              FRAME_FLAGS: queue_route(CH_FLAGS, rebuilt, 1'b1);
              FRAME_KEYER: queue_route(CH_KEYER, rebuilt, 1'b1);
              default:     queue_route(CH_KEYBOARD, rebuilt, 1'b1);
            endcase
          end
        end else begin
          closes = 1'b0;
          if (!link_sync[3]) begin
            if (!rebuilt[7]) begin
              cmd_head      = rebuilt;
              cmd_len       = 0;
              cmd_gathering = 1'b1;
            end else if (cmd_gathering && rebuilt == (cmd_head | 8'h80)) begin
              closes = 1'b1;
            end
          end
          // A full store drops the byte, a matching closing byte included.
          if (cmd_gathering && cmd_len < COMMAND_DEPTH) begin
            cmd_store[cmd_len] = rebuilt;
            cmd_len++;
            if (closes) begin
              cmd_gathering = 1'b0;
              for (int i = 0; i < cmd_len; i++) begin
                queue_route(CH_CONTROL, cmd_store[i], i == cmd_len - 1);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    routed_byte_t want;
    if (rst) begin
      expected_routes.delete();
      link_sync     = 8'h00;
      link_sync_ok  = 1'b1;
      link_frame    = 3'd0;
      byte_no       = 3'd0;
      cmd_head      = 8'h00;
      cmd_gathering = 1'b1;
      cmd_len       = 0;
    end else begin
      // Results leave a register, so a result seen here never stems from this edge's item.
      if (out_valid && out_ready) begin
        if (expected_routes.size() == 0) begin
          $error("unexpected result: channel %0d data_byte 0x%02h last %0b",
                 channel, data_byte, last);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          if (channel !== want.ch) begin
            $error("channel: expected %0d, got %0d", want.ch, channel);
            mismatches++;
          end
          if (data_byte !== want.value) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.value, data_byte);
            mismatches++;
          end
          if (last !== want.tail) begin
            $error("last: expected %0b, got %0b", want.tail, last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) route_link_byte(rx_byte);
    end
    outstanding = expected_routes.size();
  end

endmodule

// File: bench/tb_frame_channel_demultiplexer.sv
// Testbench top for the frame channel demultiplexer: stimulus, idling, watchdog and verdict.
module tb_frame_channel_demultiplexer;

  // No handshake on either side for this many cycles means the block has hung. The slowest
  // legitimate stretch is a command run draining under heavy receiver stalls, which stays far
  // below this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last expected result.
  localparam int DRAIN_CYCLES = 100;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic [7:0] rx_byte   = 8'h00;
  logic       in_valid  = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic [2:0] channel;
  logic [7:0] data_byte;
  logic       last;
  logic       out_valid;

  int mismatches;
  int outstanding;
  int send_gap_pct   = 15;
  int recv_stall_pct = 60;
  int items_sent     = 0;
  int idle_cycles    = 0;

  always #5 clk = ~clk;

  frame_channel_demultiplexer i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .channel   (channel),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  fcd_route_monitor i_route_monitor (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .data_byte   (data_byte),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver stalls at random on every cycle, at the rate of the current phase. With the
  // rate at zero it takes a result on every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_channel_demultiplexer regression: fail");
      $finish;
    end
  end

  // Offers one item on the link side, starting and ending at a falling edge. Random gaps come
  // first, so idling falls before any item, whatever the block is busy with. The valid line
  // gets at most one assignment per falling edge, so back-to-back items keep it high.
  task automatic send_item(input logic [7:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    rx_byte  <= value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // A sync byte: bit 6 continues the frame sequence, then three valid marks, then the top
  // bits of the three data bytes.
  task automatic send_sync(input logic cont, input logic [2:0] marks, input logic [2:0] tops);
    send_item({1'b0, cont, marks, tops});
  endtask

  task automatic send_data();
    send_item({1'b1, 7'($urandom)});
  endtask

  // One control byte takes a fresh frame 0 and then frame 1, whose third data byte is the
  // control byte. The mark decides between a framing byte and a plain one; the top bit makes
  // a framing byte an opening one (clear) or a closing one (set).
  task automatic send_control_frame(input logic mark, input logic top, input logic [6:0] low);
    send_sync(1'b0, 3'($urandom), 3'($urandom));
    send_sync(1'b1, {2'($urandom), mark}, {2'($urandom), top});
    send_data();
    send_data();
    send_item({1'b1, low});
  endtask

  // An opening byte, a body of control bytes and a closing byte. A noisy body now and then
  // carries a framing byte, which may reopen or close the command early.
  task automatic send_command(input int body_len, input bit good_close, input bit noisy);
    logic [6:0] head_low;
    head_low = 7'($urandom);
    send_control_frame(1'b0, 1'b0, head_low);
    repeat (body_len) begin
      if (noisy && $urandom_range(7) == 0) begin
        send_control_frame(1'b0, 1'($urandom), 7'($urandom));
      end else begin
        send_control_frame(1'b1, 1'($urandom), 7'($urandom));
      end
    end
    if (good_close) begin
      send_control_frame(1'b0, 1'b1, head_low);
    end else begin
      send_control_frame(1'b0, 1'b1, head_low ^ 7'($urandom_range(1, 127)));
    end
  endtask

  // A sequence of frames from frame 0; five or six run past the fourth and spoil the sequence.
  // Most frames carry three data bytes; some carry none, too few or extra ones.
  task automatic send_frames(input int frames);
    int count;
    for (int f = 0; f < frames; f++) begin
      send_sync(f != 0, 3'($urandom), 3'($urandom));
      count = ($urandom_range(4) == 0) ? $urandom_range(0, 5) : 3;
      repeat (count) send_data();
    end
  endtask

  // Mostly well-formed frames and commands with random content, with stray control frames
  // and raw noise bytes mixed in.
  task automatic send_random_traffic(input int budget);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_frames($urandom_range(1, 6));
      end else if (pick < 75) begin
        send_command($urandom_range(0, 6), $urandom_range(3) != 0, 1'b1);
      end else if (pick < 88) begin
        send_control_frame(1'($urandom), 1'($urandom), 7'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(8'($urandom));
      end
    end
  endtask

  // Holds the link side idle until every predicted result has arrived.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase one: the sender idles a little, the receiver a lot.
    send_gap_pct   = 15;
    recv_stall_pct = 60;

    // Directed part. A frame 0 sync with no valid marks leaves its data byte unrouted.
    send_item(8'h00);
    send_item(8'h80);
    // All marks and top bits set: radio 1, radio 2 and flags, with the field extremes.
    send_item(8'h3f);
    send_item(8'h80);
    send_item(8'hff);
    send_item(8'haa);
    // Frame 1 with every top bit clear. Gathering is active from reset, so the plain
    // control byte goes into the store.
    send_item(8'h78);
    send_item(8'hff);
    send_item(8'h80);
    send_item(8'h85);
    // Frames 2 and 3 route the third byte to the keyer and the keyboard, and an extra data
    // byte beyond the third is ignored.
    send_item(8'h7f);
    send_item(8'hd5);
    send_item(8'h80);
    send_item(8'hc3);
    send_item(8'h7f);
    send_item(8'h81);
    send_item(8'hfe);
    send_item(8'h9c);
    send_item(8'hf0);
    // Frame 4 is one too many: its data bytes yield nothing.
    send_item(8'h7f);
    send_item(8'h8f);
    send_item(8'hf8);
    // Back to frame 0, then frame 1 with a closing byte that matches the reset head, which
    // sends the stored command as a run of two.
    send_item(8'h00);
    send_item(8'h41);
    send_item(8'h80);
    send_item(8'h80);
    send_item(8'h80);

    // The longest run: the opening byte, thirty plain ones and the closing byte fill all
    // thirty-two entries.
    send_command(30, 1'b1, 1'b0);
    wait_for_quiet();

    // Phase two: the roles of the two sides swap.
    send_gap_pct   = 60;
    recv_stall_pct = 15;
    send_random_traffic(20);
    wait_for_quiet();

    // Phase three: no idling at all. A body that fills the store leaves no room for the
    // closing byte, which is dropped, and gathering stays active.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_command(31, 1'b1, 1'b0);

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("frame_channel_demultiplexer regression: pass");
    end else begin
      $display("frame_channel_demultiplexer regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fcd_pkg.sv
rtl/fcd_controller.sv
rtl/fcd_datapath.sv
rtl/frame_channel_demultiplexer.sv
bench/fcd_route_monitor.sv
bench/tb_frame_channel_demultiplexer.sv
